### hdl/mips_subset_single_cycle_cpu_core_macros.svh
// Assertion macros shared by the core's top level.
// No dependencies; included by the files that carry concurrent checks.
`ifndef MIPS_SUBSET_SINGLE_CYCLE_CPU_CORE_MACROS_SVH
`define MIPS_SUBSET_SINGLE_CYCLE_CPU_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define MSSCC_ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("msscc check failed (same cycle)");

// next-cycle implication, disabled while reset is asserted
`define MSSCC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("msscc check failed (next cycle)");

`endif

### hdl/msscc_pkg.sv
// Shared types and constants of the MIPS subset core.
// No dependencies; used by the controller, the datapath and the top level.
package msscc_pkg;

  localparam int MEM_DEPTH_DEF = 64;
  localparam int REG_COUNT     = 32;
  localparam int XLEN          = 32;

  // request codes
  localparam logic [1:0] REQ_LOAD_MEM = 2'd0;
  localparam logic [1:0] REQ_LOAD_REG = 2'd1;
  localparam logic [1:0] REQ_STEP     = 2'd2;

  // opcodes
  localparam logic [5:0] OPC_RTYPE = 6'd0;
  localparam logic [5:0] OPC_J     = 6'd2;
  localparam logic [5:0] OPC_BEQ   = 6'd4;
  localparam logic [5:0] OPC_LW    = 6'd35;
  localparam logic [5:0] OPC_SW    = 6'd43;

  // R-type funct codes
  localparam logic [5:0] FN_ADD = 6'd32;
  localparam logic [5:0] FN_SUB = 6'd34;
  localparam logic [5:0] FN_AND = 6'd36;
  localparam logic [5:0] FN_OR  = 6'd37;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_EXEC,
    ST_MOD,
    ST_MEMRD,
    ST_LWWB,
    ST_SWWR,
    ST_LDMEM
  } state_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_CLEAR,
    DP_CAPTURE,
    DP_DECODE,
    DP_LDREG,
    DP_MODLD,
    DP_EXEC,
    DP_MEMRD,
    DP_LWWB,
    DP_SWWR,
    DP_LDMEM
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   report;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       halted;
    logic       is_mem;
    logic       is_lw;
    logic       mod_busy;
    logic       clr_last;
  } dp_status_t;

endpackage

### hdl/msscc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for the register file and the word memory.
module msscc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/msscc_ctrl.sv
// Controller state machine of the MIPS subset core.
// Depends on msscc_pkg; drives datapath commands from datapath status.
module msscc_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  msscc_pkg::dp_status_t  status,
  output msscc_pkg::dp_cmd_t     cmd
);

  msscc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msscc_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd.op     = msscc_pkg::DP_NONE;
    cmd.report = 1'b0;
    busy       = 1'b1;
    case (state_r)
      msscc_pkg::ST_CLEAR: begin
        cmd.op = msscc_pkg::DP_CLEAR;
        if (status.clr_last) begin
          state_nxt = msscc_pkg::ST_IDLE;
        end
      end
      msscc_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.op    = msscc_pkg::DP_CAPTURE;
          state_nxt = msscc_pkg::ST_DISPATCH;
        end
      end
      msscc_pkg::ST_DISPATCH: begin
        case (status.req)
          msscc_pkg::REQ_LOAD_MEM: begin
            cmd.op    = msscc_pkg::DP_MODLD;
            state_nxt = msscc_pkg::ST_MOD;
          end
          msscc_pkg::REQ_LOAD_REG: begin
            cmd.op     = msscc_pkg::DP_LDREG;
            cmd.report = 1'b1;
            state_nxt  = msscc_pkg::ST_IDLE;
          end
          msscc_pkg::REQ_STEP: begin
            if (status.halted) begin
              cmd.report = 1'b1;
              state_nxt  = msscc_pkg::ST_IDLE;
            end else begin
              cmd.op    = msscc_pkg::DP_DECODE;
              state_nxt = msscc_pkg::ST_EXEC;
            end
          end
          default: begin
            cmd.report = 1'b1;
            state_nxt  = msscc_pkg::ST_IDLE;
          end
        endcase
      end
      msscc_pkg::ST_EXEC: begin
        cmd.op = msscc_pkg::DP_EXEC;
        if (status.is_mem) begin
          state_nxt = msscc_pkg::ST_MOD;
        end else begin
          cmd.report = 1'b1;
          state_nxt  = msscc_pkg::ST_IDLE;
        end
      end
      msscc_pkg::ST_MOD: begin
        // wait for the address reduction to settle
        if (!status.mod_busy) begin
          if (status.req == msscc_pkg::REQ_LOAD_MEM) begin
            state_nxt = msscc_pkg::ST_LDMEM;
          end else if (status.is_lw) begin
            state_nxt = msscc_pkg::ST_MEMRD;
          end else begin
            state_nxt = msscc_pkg::ST_SWWR;
          end
        end
      end
      msscc_pkg::ST_MEMRD: begin
        cmd.op    = msscc_pkg::DP_MEMRD;
        state_nxt = msscc_pkg::ST_LWWB;
      end
      msscc_pkg::ST_LWWB: begin
        cmd.op     = msscc_pkg::DP_LWWB;
        cmd.report = 1'b1;
        state_nxt  = msscc_pkg::ST_IDLE;
      end
      msscc_pkg::ST_SWWR: begin
        cmd.op     = msscc_pkg::DP_SWWR;
        cmd.report = 1'b1;
        state_nxt  = msscc_pkg::ST_IDLE;
      end
      msscc_pkg::ST_LDMEM: begin
        cmd.op     = msscc_pkg::DP_LDMEM;
        cmd.report = 1'b1;
        state_nxt  = msscc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = msscc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/msscc_dp.sv
// Datapath of the MIPS subset core: PC, memories, ALU, address reduction, result registers.
// Depends on msscc_pkg and msscc_ram; commanded by msscc_ctrl.
module msscc_dp #(
  parameter int MEM_DEPTH = msscc_pkg::MEM_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  msscc_pkg::dp_cmd_t    cmd,
  output msscc_pkg::dp_status_t status,
  input  logic [1:0]            in_req_type,
  input  logic [5:0]            in_load_index,
  input  logic [31:0]           in_load_value,
  output logic                  out_valid,
  output logic [31:0]           out_pc_after,
  output logic [31:0]           out_instruction,
  output logic                  out_reg_written,
  output logic [4:0]            out_reg_idx,
  output logic [31:0]           out_reg_value,
  output logic                  out_mem_written,
  output logic [5:0]            out_mem_idx,
  output logic [31:0]           out_mem_value,
  output logic                  out_branch_taken,
  output logic                  out_halted
);

  localparam int AW    = $clog2(MEM_DEPTH);
  localparam bit POW2  = ((MEM_DEPTH & (MEM_DEPTH - 1)) == 0);
  localparam int CLR_N = (MEM_DEPTH > msscc_pkg::REG_COUNT) ? MEM_DEPTH
                                                            : msscc_pkg::REG_COUNT;
  localparam int CW    = $clog2(CLR_N);
  localparam int RW    = $clog2(msscc_pkg::REG_COUNT);
  // floor(2^32 / depth); the quotient estimate is low by at most one
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(MEM_DEPTH));

  // control registers
  logic [CW-1:0] clr_r;
  logic [31:0]   pc_r;
  logic          halted_r;
  logic          mod_busy_r;
  logic          out_valid_r;

  // payload registers
  logic [1:0]    req_r;
  logic [5:0]    lidx_r;
  logic [31:0]   lval_r;
  logic [31:0]   inst_r;
  logic [31:0]   b_r;
  logic [31:0]   mod_x_r;
  logic [31:0]   mod_q_r;
  logic [31:0]   mod_diff_r;
  logic [AW-1:0] rem_r;
  logic [1:0]    mod_cnt_r;
  logic          rw_r;
  logic [4:0]    ri_r;
  logic [31:0]   rv_r;
  logic          mw_r;
  logic [5:0]    mi_r;
  logic [31:0]   mv_r;
  logic          br_r;

  // memory ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata, mem_rdata;
  logic          rf_we;
  logic [RW-1:0] rf_waddr;
  logic [31:0]   rf_wdata, rfa_rdata, rfb_rdata;

  // decode and execute
  logic [5:0]    opc, fn;
  logic [4:0]    rt, rd;
  logic [31:0]   imm, pc4, addr_sum, alu_res, pc_nxt, mod_src;
  logic          alu_ok, is_mem, is_lw, beq_eq, pc_upd, mod_start, clr_in_mem;
  logic [63:0]   mod_prod;
  logic [31:0]   mod_qd, mod_diff;

  assign opc      = inst_r[31:26];
  assign fn       = inst_r[5:0];
  assign rt       = inst_r[20:16];
  assign rd       = inst_r[15:11];
  assign imm      = {{16{inst_r[15]}}, inst_r[15:0]};
  assign pc4      = pc_r + 32'd4;
  assign addr_sum = rfa_rdata + imm;
  assign beq_eq   = (rfa_rdata == rfb_rdata);
  assign is_lw    = (opc == msscc_pkg::OPC_LW);
  assign is_mem   = is_lw || (opc == msscc_pkg::OPC_SW);
  assign clr_in_mem = (32'(clr_r) < 32'(MEM_DEPTH));

  always_comb begin
    alu_ok  = 1'b1;
    alu_res = '0;
    case (fn)
      msscc_pkg::FN_ADD: alu_res = rfa_rdata + rfb_rdata;
      msscc_pkg::FN_SUB: alu_res = rfa_rdata - rfb_rdata;
      msscc_pkg::FN_AND: alu_res = rfa_rdata & rfb_rdata;
      msscc_pkg::FN_OR:  alu_res = rfa_rdata | rfb_rdata;
      default:           alu_ok  = 1'b0;
    endcase
  end

  // next PC
  always_comb begin
    pc_upd = 1'b0;
    pc_nxt = pc4;
    case (cmd.op)
      msscc_pkg::DP_EXEC: begin
        pc_upd = !is_mem;
        case (opc)
          msscc_pkg::OPC_BEQ: begin
            if (beq_eq) begin
              pc_nxt = pc4 + {imm[29:0], 2'b00};
            end
          end
          msscc_pkg::OPC_J: pc_nxt = {pc4[31:28], inst_r[25:0], 2'b00};
          default:          pc_nxt = pc4;
        endcase
      end
      msscc_pkg::DP_LWWB, msscc_pkg::DP_SWWR: pc_upd = 1'b1;
      default: pc_upd = 1'b0;
    endcase
  end

  // address reduction modulo the depth: a mask for powers of two, else a
  // reciprocal multiply, a back-multiply and one conditional subtract
  assign mod_start = (cmd.op == msscc_pkg::DP_MODLD) || ((cmd.op == msscc_pkg::DP_EXEC) && is_mem);
  assign mod_src   = (cmd.op == msscc_pkg::DP_MODLD) ? {26'd0, lidx_r} : addr_sum;
  assign mod_prod  = {32'd0, mod_x_r} * {32'd0, RECIP};
  assign mod_qd    = mod_q_r * 32'(MEM_DEPTH);
  assign mod_diff  = mod_x_r - mod_qd;

  // word memory port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rem_r;
    mem_wdata = lval_r;
    mem_raddr = (cmd.op == msscc_pkg::DP_MEMRD) ? rem_r : pc_r[AW-1:0];
    case (cmd.op)
      msscc_pkg::DP_CLEAR: begin
        mem_we    = clr_in_mem;
        mem_waddr = clr_r[AW-1:0];
        mem_wdata = '0;
      end
      msscc_pkg::DP_LDMEM: mem_we = 1'b1;
      msscc_pkg::DP_SWWR: begin
        mem_we    = 1'b1;
        mem_wdata = b_r;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // register file write port
  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = lidx_r[RW-1:0];
    rf_wdata = lval_r;
    case (cmd.op)
      msscc_pkg::DP_CLEAR: begin
        rf_we    = 1'b1;
        rf_waddr = clr_r[RW-1:0];
        rf_wdata = '0;
      end
      msscc_pkg::DP_LDREG: rf_we = 1'b1;
      msscc_pkg::DP_EXEC: begin
        rf_we    = (opc == msscc_pkg::OPC_RTYPE) && alu_ok;
        rf_waddr = rd;
        rf_wdata = alu_res;
      end
      msscc_pkg::DP_LWWB: begin
        rf_we    = 1'b1;
        rf_waddr = rt;
        rf_wdata = mem_rdata;
      end
      default: rf_we = 1'b0;
    endcase
  end

  msscc_ram #(.WIDTH(32), .DEPTH(MEM_DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // two copies of the register file give the rs and rt reads in the same cycle
  msscc_ram #(.WIDTH(32), .DEPTH(msscc_pkg::REG_COUNT)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (mem_rdata[25:21]),
    .rdata (rfa_rdata)
  );

  msscc_ram #(.WIDTH(32), .DEPTH(msscc_pkg::REG_COUNT)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (mem_rdata[20:16]),
    .rdata (rfb_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      pc_r        <= '0;
      halted_r    <= 1'b0;
      mod_busy_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.report;
      if (cmd.op == msscc_pkg::DP_CLEAR) begin
        clr_r <= clr_r + CW'(1);
      end
      if (pc_upd) begin
        pc_r     <= pc_nxt;
        halted_r <= (pc_nxt >= 32'(MEM_DEPTH));
      end
      if (mod_start) begin
        mod_busy_r <= !POW2;
      end else if (mod_busy_r && (mod_cnt_r == 2'd1)) begin
        mod_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mod_start) begin
      if (POW2) begin
        rem_r <= mod_src[AW-1:0];
      end else begin
        mod_x_r   <= mod_src;
        mod_cnt_r <= 2'd3;
      end
    end else if (mod_busy_r) begin
      case (mod_cnt_r)
        2'd3: mod_q_r <= mod_prod[63:32];
        2'd2: mod_diff_r <= mod_diff;
        default: begin
          rem_r <= AW'((mod_diff_r >= 32'(MEM_DEPTH)) ? (mod_diff_r - 32'(MEM_DEPTH))
                                                      : mod_diff_r);
        end
      endcase
      mod_cnt_r <= mod_cnt_r - 2'd1;
    end

    case (cmd.op)
      msscc_pkg::DP_CAPTURE: begin
        req_r  <= in_req_type;
        lidx_r <= in_load_index;
        lval_r <= in_load_value;
        inst_r <= '0;
        rw_r   <= 1'b0;
        ri_r   <= '0;
        rv_r   <= '0;
        mw_r   <= 1'b0;
        mi_r   <= '0;
        mv_r   <= '0;
        br_r   <= 1'b0;
      end
      msscc_pkg::DP_DECODE: inst_r <= mem_rdata;
      msscc_pkg::DP_LDREG: begin
        rw_r <= 1'b1;
        ri_r <= lidx_r[4:0];
        rv_r <= lval_r;
      end
      msscc_pkg::DP_EXEC: begin
        b_r <= rfb_rdata;
        if ((opc == msscc_pkg::OPC_RTYPE) && alu_ok) begin
          rw_r <= 1'b1;
          ri_r <= rd;
          rv_r <= alu_res;
        end
        if (((opc == msscc_pkg::OPC_BEQ) && beq_eq) || (opc == msscc_pkg::OPC_J)) begin
          br_r <= 1'b1;
        end
      end
      msscc_pkg::DP_LWWB: begin
        rw_r <= 1'b1;
        ri_r <= rt;
        rv_r <= mem_rdata;
      end
      msscc_pkg::DP_SWWR: begin
        mw_r <= 1'b1;
        mi_r <= 6'(rem_r);
        mv_r <= b_r;
      end
      msscc_pkg::DP_LDMEM: begin
        mw_r <= 1'b1;
        mi_r <= 6'(rem_r);
        mv_r <= lval_r;
      end
      default: begin
      end
    endcase
  end

  assign status.req      = req_r;
  assign status.halted   = halted_r;
  assign status.is_mem   = is_mem;
  assign status.is_lw    = is_lw;
  assign status.mod_busy = mod_busy_r;
  assign status.clr_last = (clr_r == CW'(CLR_N - 1));

  assign out_valid        = out_valid_r;
  assign out_pc_after     = pc_r;
  assign out_instruction  = inst_r;
  assign out_reg_written  = rw_r;
  assign out_reg_idx      = ri_r;
  assign out_reg_value    = rv_r;
  assign out_mem_written  = mw_r;
  assign out_mem_idx      = mi_r;
  assign out_mem_value    = mv_r;
  assign out_branch_taken = br_r;
  assign out_halted       = halted_r;

endmodule

### hdl/mips_subset_single_cycle_cpu_core.sv
// MIPS subset core (lw, sw, beq, j, add/sub/and/or); one result strobe per item.
// Memory loads, sw and lw reduce their address modulo MEM_DEPTH: by a mask when it is a
// power of two, else by a multiply-based address reduction.
// Next item accepted in the strobe cycle; results are never held off. After reset a clearing
// pass zeroes both memories with busy high. Needs msscc_pkg.
`include "mips_subset_single_cycle_cpu_core_macros.svh"

module mips_subset_single_cycle_cpu_core #(
  parameter int MEM_DEPTH = msscc_pkg::MEM_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [5:0]  in_load_index,
  input  logic [31:0] in_load_value,
  output logic        out_valid,
  output logic [31:0] out_pc_after,
  output logic [31:0] out_instruction,
  output logic        out_reg_written,
  output logic [4:0]  out_reg_idx,
  output logic [31:0] out_reg_value,
  output logic        out_mem_written,
  output logic [5:0]  out_mem_idx,
  output logic [31:0] out_mem_value,
  output logic        out_branch_taken,
  output logic        out_halted
);

  msscc_pkg::dp_cmd_t    cmd;
  msscc_pkg::dp_status_t status;

  msscc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  msscc_dp #(.MEM_DEPTH(MEM_DEPTH)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_req_type      (in_req_type),
    .in_load_index    (in_load_index),
    .in_load_value    (in_load_value),
    .out_valid        (out_valid),
    .out_pc_after     (out_pc_after),
    .out_instruction  (out_instruction),
    .out_reg_written  (out_reg_written),
    .out_reg_idx      (out_reg_idx),
    .out_reg_value    (out_reg_value),
    .out_mem_written  (out_mem_written),
    .out_mem_idx      (out_mem_idx),
    .out_mem_value    (out_mem_value),
    .out_branch_taken (out_branch_taken),
    .out_halted       (out_halted)
  );

  // a result transfer only shows once the controller is back in idle
  `MSSCC_ASSERT_SAME(a_strobe_idle, clk, rst_n, out_valid, !busy)
  `MSSCC_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `MSSCC_ASSERT_SAME(a_halt_pc, clk, rst_n, out_valid,
                     out_halted == (out_pc_after >= 32'(MEM_DEPTH)))
  `MSSCC_ASSERT_SAME(a_quiet_fields, clk, rst_n, out_valid && !out_reg_written,
                     (out_reg_idx == 5'd0) && (out_reg_value == 32'd0))

endmodule
